// ===== rtl/core/rci_pkg.sv =====
// Shared widths and latencies for the ray / circle intersection core.
package rci_pkg;

   localparam int CW   = 32;            // coordinate width
   localparam int DW   = CW + 1;        // origin minus centre
   localparam int AW   = 2 * CW;        // |D|^2
   localparam int HW   = 2 * DW;        // r.D, r x D, |r|^2
   localparam int RSW  = 2 * (CW - 1);  // radius squared
   localparam int ML   = 23;            // wide multiplier limb
   localparam int MW   = 3 * ML;        // wide multiplier operand
   localparam int PW   = 2 * MW;        // wide multiplier product
   localparam int SW   = (AW + RSW) / 2; // square root width
   localparam int NW   = HW + 1;        // root numerator, signed
   localparam int TW   = NW + CW + 3;   // 2*N*d + a, signed
   localparam int TMW  = TW - 1;        // its magnitude
   localparam int DENW = AW + 1;        // 2*a
   localparam int QW   = CW + 3;        // quotient magnitude
   localparam int FW   = QW + 2;        // point before saturation
   localparam int MUL_LAT = 3;

endpackage

// ===== rtl/core/rci_wmul.sv =====
// Three-stage unsigned wide multiplier built from limb partial products.
module rci_wmul
   import rci_pkg::*;
(
   input  logic          clock,
   input  logic          en,
   input  logic [MW-1:0] op_a,
   input  logic [MW-1:0] op_b,
   output logic [PW-1:0] prod
);

   localparam int NL  = MW / ML;
   localparam int RWD = (NL + 1) * ML;

   logic [2*ML-1:0] pp_ff  [NL][NL];
   logic [RWD-1:0]  row_ff [NL];
   logic [RWD-1:0]  row_in [NL];
   logic [PW-1:0]   prod_ff;
   logic [PW-1:0]   prod_in;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NL; j++) begin
            row_in[i] = row_in[i] + (RWD'(pp_ff[i][j]) << (j * ML));
         end
      end
      prod_in = '0;
      for (int i = 0; i < NL; i++) begin
         prod_in = prod_in + (PW'(row_ff[i]) << (i * ML));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
               pp_ff[i][j] <= op_a[i*ML +: ML] * op_b[j*ML +: ML];
            end
            row_ff[i] <= row_in[i];
         end
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/rci_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rci_sqrt
   import rci_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  logic [2*SW-1:0] radicand,
   output logic [SW-1:0]   root
);

   logic [2*SW-1:0] rem_ff  [SW];
   logic [SW-1:0]   root_ff [SW];

   for (genvar j = 0; j < SW; j++) begin : g_stage
      localparam int K = SW - 1 - j;
      logic [2*SW-1:0] prem;
      logic [SW-1:0]   proot;
      logic [2*SW-1:0] trial;
      logic [2*SW-1:0] rem_in;
      logic [SW-1:0]   root_in;

      if (j == 0) begin : g_first
         assign prem  = radicand;
         assign proot = '0;
      end else begin : g_next
         assign prem  = rem_ff[j-1];
         assign proot = root_ff[j-1];
      end

      assign trial = ({{SW{1'b0}}, proot} << (K + 1)) |
                     ({{(2*SW-1){1'b0}}, 1'b1} << (2 * K));

      always_comb begin
         if (prem >= trial) begin
            rem_in  = prem - trial;
            root_in = proot | ({{(SW-1){1'b0}}, 1'b1} << K);
         end else begin
            rem_in  = prem;
            root_in = proot;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
         end
      end
   end

   assign root = root_ff[SW-1];

endmodule

// ===== rtl/core/rci_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rci_div
   import rci_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  logic [TMW-1:0]  num,
   input  logic [DENW-1:0] den,
   output logic [QW-1:0]   quo,
   output logic            rem_nz
);

   logic [TMW-1:0]  rem_ff [QW];
   logic [QW-1:0]   quo_ff [QW];
   logic [DENW-1:0] den_ff [QW-1];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      localparam int K = QW - 1 - j;
      logic [TMW-1:0]  prem;
      logic [QW-1:0]   pquo;
      logic [DENW-1:0] pden;
      logic [TMW-1:0]  sub;
      logic [TMW-1:0]  rem_in;
      logic [QW-1:0]   quo_in;

      if (j == 0) begin : g_first
         assign prem = num;
         assign pquo = '0;
         assign pden = den;
      end else begin : g_next
         assign prem = rem_ff[j-1];
         assign pquo = quo_ff[j-1];
         assign pden = den_ff[j-1];
      end

      if (j < QW - 1) begin : g_den
         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[j] <= pden;
            end
         end
      end

      assign sub = {{(TMW-DENW){1'b0}}, pden} << K;

      always_comb begin
         if (prem >= sub) begin
            rem_in = prem - sub;
            quo_in = pquo | ({{(QW-1){1'b0}}, 1'b1} << K);
         end else begin
            rem_in = prem;
            quo_in = pquo;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quo    = quo_ff[QW-1];
   assign rem_nz = |rem_ff[QW-1];

endmodule

// ===== rtl/core/ray_circle_intersection_core.sv =====
// Ray / circle intersection core: fully pipelined exact quadratic solver.
//
// Input channel req_*: one beat carries a ray origin, a direction, a circle
// centre and a radius, all raw fixed point. Result channel rsp_*: one beat per
// input beat, in order, with the hit count and up to two points, nearer first;
// slots beyond the count read zero and coordinates saturate to 32 bits.
// The pipeline takes one beat every cycle while req_ready is high. Depth is
// set by the 63-stage square root and the 35-stage point divider, one bit
// per stage each.
// Stall: an output register plus one skid entry decouple rsp from the
// pipeline. When rsp_ready stays low the skid entry fills, req_ready drops
// and the whole pipeline holds; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits, which empties both
// output entries; no result is pending afterwards.
module ray_circle_intersection_core
   import rci_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [CW-1:0] req_origin_x,
   input  logic signed [CW-1:0] req_origin_y,
   input  logic signed [CW-1:0] req_dir_x,
   input  logic signed [CW-1:0] req_dir_y,
   input  logic signed [CW-1:0] req_center_x,
   input  logic signed [CW-1:0] req_center_y,
   input  logic [CW-2:0]        req_circle_radius,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_hit_count,
   output logic signed [CW-1:0] rsp_first_x,
   output logic signed [CW-1:0] rsp_first_y,
   output logic signed [CW-1:0] rsp_second_x,
   output logic signed [CW-1:0] rsp_second_y
);

   localparam int NSTAGE = 4 + MUL_LAT + 1 + SW + 2 + MUL_LAT + 2 + QW + 1;
   localparam logic signed [FW-1:0] PMAX = FW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [FW-1:0] PMIN = -PMAX - FW'(1);

   typedef struct packed {
      logic signed [CW-1:0] ox;
      logic signed [CW-1:0] oy;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic [AW-1:0]        a;
      logic signed [HW-1:0] h;
      logic                 cneg;
      logic                 cpos;
      logic                 azero;
      logic                 dpos;
      logic                 dzero;
   } geo_type;

   typedef struct packed {
      logic signed [CW-1:0] ox;
      logic signed [CW-1:0] oy;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic [AW-1:0]        a;
      logic [1:0]           cnt;
      logic signed [NW-1:0] n0;
      logic signed [NW-1:0] n1;
   } num_type;

   typedef struct packed {
      logic signed [CW-1:0] ox;
      logic signed [CW-1:0] oy;
      logic [AW-1:0]        a;
      logic [1:0]           cnt;
      logic [3:0]           neg;
   } fin_type;

   typedef struct packed {
      logic [1:0]           cnt;
      logic signed [CW-1:0] fx;
      logic signed [CW-1:0] fy;
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
   } rsp_type;

   logic              en;
   logic [NSTAGE-1:0] vld_ff;
   logic              pv;

   // stage 1
   logic signed [CW-1:0] ox1_ff, oy1_ff, dx1_ff, dy1_ff;
   logic signed [DW-1:0] rx1_ff, ry1_ff;
   logic [CW-2:0]        rad1_ff;
   // stage 2
   logic signed [CW-1:0] ox2_ff, oy2_ff, dx2_ff, dy2_ff;
   logic signed [AW-1:0] pddx2_ff, pddy2_ff;
   logic signed [HW-2:0] prdx2_ff, prdy2_ff, pcx2_ff, pcy2_ff;
   logic signed [HW-1:0] prrx2_ff, prry2_ff;
   logic [RSW-1:0]       prad2_ff;
   // stage 3
   logic signed [CW-1:0] ox3_ff, oy3_ff, dx3_ff, dy3_ff;
   logic [AW-1:0]        a3_ff;
   logic signed [HW-1:0] h3_ff, cross3_ff;
   logic [HW-1:0]        rr3_ff;
   logic [RSW-1:0]       radsq3_ff;
   // stage 4
   geo_type              s4_ff, s4_in;
   logic [HW-1:0]        xabs4_ff;
   logic [RSW-1:0]       radsq4_ff;
   logic [PW-1:0]        arr, cc;
   geo_type              sa_ff [MUL_LAT];
   // stage 8
   geo_type              s8_ff, s8_in;
   logic [2*SW-1:0]      disc8_ff, disc8_in;
   logic [PW:0]          dd;
   geo_type              sq_ff [SW];
   logic [SW-1:0]        sroot;
   // stage 72
   num_type              s72_ff, s72_in;
   geo_type              g;
   logic signed [NW-1:0] nh, na, nb;
   logic                 t1, t2;
   // stage 73
   fin_type              s73_ff, s73_in;
   logic [MW-1:0]        mopa_ff [4], mopb_ff [4];
   logic [MW-1:0]        mopa_in [4], mopb_in [4];
   logic [PW-1:0]        mprod [4];
   logic signed [NW-1:0] nsel;
   logic signed [CW-1:0] dsel;
   logic [NW-1:0]        nmag;
   logic [CW-1:0]        dmag;
   fin_type              sb_ff [MUL_LAT];
   // stage 77
   fin_type              s77_ff;
   logic signed [TW-1:0] top77_ff [4], top77_in [4];
   // stage 78
   fin_type              s78_ff, s78_in;
   logic [TMW-1:0]       tabs78_ff [4], tabs78_in [4];
   fin_type              sc_ff [QW];
   logic [QW-1:0]        dquo [4];
   logic                 drnz [4];
   // stage 114
   rsp_type              res_ff, res_in;
   logic signed [FW-1:0] pt [4];
   // output entries
   rsp_type              out_ff, skid_ff;
   logic                 out_valid_ff, skid_valid_ff;

   assign en        = !skid_valid_ff;
   assign req_ready = en;
   assign pv        = en && vld_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_valid};
      end
   end

   // operand differences and products, their sums and |r x D|
   always_ff @(posedge clock) begin
      if (en) begin
         ox1_ff  <= req_origin_x;
         oy1_ff  <= req_origin_y;
         dx1_ff  <= req_dir_x;
         dy1_ff  <= req_dir_y;
         rx1_ff  <= DW'(req_origin_x) - DW'(req_center_x);
         ry1_ff  <= DW'(req_origin_y) - DW'(req_center_y);
         rad1_ff <= req_circle_radius;

         ox2_ff   <= ox1_ff;
         oy2_ff   <= oy1_ff;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         pddx2_ff <= dx1_ff * dx1_ff;
         pddy2_ff <= dy1_ff * dy1_ff;
         prdx2_ff <= rx1_ff * dx1_ff;
         prdy2_ff <= ry1_ff * dy1_ff;
         pcx2_ff  <= rx1_ff * dy1_ff;
         pcy2_ff  <= ry1_ff * dx1_ff;
         prrx2_ff <= rx1_ff * rx1_ff;
         prry2_ff <= ry1_ff * ry1_ff;
         prad2_ff <= rad1_ff * rad1_ff;

         ox3_ff    <= ox2_ff;
         oy3_ff    <= oy2_ff;
         dx3_ff    <= dx2_ff;
         dy3_ff    <= dy2_ff;
         a3_ff     <= $unsigned(pddx2_ff) + $unsigned(pddy2_ff);
         h3_ff     <= HW'(prdx2_ff) + HW'(prdy2_ff);
         cross3_ff <= HW'(pcx2_ff) - HW'(pcy2_ff);
         rr3_ff    <= $unsigned(prrx2_ff) + $unsigned(prry2_ff);
         radsq3_ff <= prad2_ff;

         s4_ff     <= s4_in;
         xabs4_ff  <= cross3_ff[HW-1] ? $unsigned(-cross3_ff) : $unsigned(cross3_ff);
         radsq4_ff <= radsq3_ff;
      end
   end

   always_comb begin
      s4_in       = '0;
      s4_in.ox    = ox3_ff;
      s4_in.oy    = oy3_ff;
      s4_in.dx    = dx3_ff;
      s4_in.dy    = dy3_ff;
      s4_in.a     = a3_ff;
      s4_in.h     = h3_ff;
      s4_in.cneg  = rr3_ff < {{(HW-RSW){1'b0}}, radsq3_ff};
      s4_in.cpos  = rr3_ff > {{(HW-RSW){1'b0}}, radsq3_ff};
      s4_in.azero = a3_ff == '0;
   end

   // discriminant as |D|^2 R^2 - (r x D)^2
   rci_wmul u_mul_arr (
      .clock (clock),
      .en    (en),
      .op_a  ({{(MW-AW){1'b0}}, s4_ff.a}),
      .op_b  ({{(MW-RSW){1'b0}}, radsq4_ff}),
      .prod  (arr)
   );

   rci_wmul u_mul_cc (
      .clock (clock),
      .en    (en),
      .op_a  ({{(MW-HW){1'b0}}, xabs4_ff}),
      .op_b  ({{(MW-HW){1'b0}}, xabs4_ff}),
      .prod  (cc)
   );

   always_comb begin
      dd          = {1'b0, arr} - {1'b0, cc};
      s8_in       = sa_ff[MUL_LAT-1];
      s8_in.dzero = dd == '0;
      s8_in.dpos  = !dd[PW] && (dd != '0);
      disc8_in    = s8_in.dpos ? dd[2*SW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff[0] <= s4_ff;
         for (int i = 1; i < MUL_LAT; i++) begin
            sa_ff[i] <= sa_ff[i-1];
         end
         s8_ff    <= s8_in;
         disc8_ff <= disc8_in;
         sq_ff[0] <= s8_ff;
         for (int i = 1; i < SW; i++) begin
            sq_ff[i] <= sq_ff[i-1];
         end
      end
   end

   rci_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (disc8_ff),
      .root     (sroot)
   );

   // root selection and packing
   always_comb begin
      g  = sq_ff[SW-1];
      nh = -{g.h[HW-1], g.h};
      na = nh - {{(NW-SW){1'b0}}, sroot};
      nb = nh + {{(NW-SW){1'b0}}, sroot};
      t1 = g.h[HW-1] && g.cpos;
      t2 = g.h[HW-1] || g.cneg;
      s72_in    = '0;
      s72_in.ox = g.ox;
      s72_in.oy = g.oy;
      s72_in.dx = g.dx;
      s72_in.dy = g.dy;
      s72_in.a  = g.a;
      s72_in.n0 = nb;
      s72_in.n1 = nb;
      if (g.azero) begin
         s72_in.cnt = 2'd0;
      end else if (g.dzero) begin
         s72_in.cnt = g.h[HW-1] ? 2'd1 : 2'd0;
         s72_in.n0  = nh;
      end else if (g.dpos) begin
         s72_in.cnt = {1'b0, t1} + {1'b0, t2};
         s72_in.n0  = t1 ? na : nb;
      end else begin
         s72_in.cnt = 2'd0;
      end
   end

   always_comb begin
      s73_in     = '0;
      s73_in.ox  = s72_ff.ox;
      s73_in.oy  = s72_ff.oy;
      s73_in.a   = s72_ff.a;
      s73_in.cnt = s72_ff.cnt;
      for (int i = 0; i < 4; i++) begin
         nsel = (i < 2) ? s72_ff.n0 : s72_ff.n1;
         dsel = (i % 2 == 0) ? s72_ff.dx : s72_ff.dy;
         nmag = nsel[NW-1] ? $unsigned(-nsel) : $unsigned(nsel);
         dmag = dsel[CW-1] ? $unsigned(-dsel) : $unsigned(dsel);
         mopa_in[i]    = {{(MW-NW){1'b0}}, nmag};
         mopb_in[i]    = {{(MW-CW){1'b0}}, dmag};
         s73_in.neg[i] = nsel[NW-1] ^ dsel[CW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s72_ff <= s72_in;
         s73_ff <= s73_in;
         for (int i = 0; i < 4; i++) begin
            mopa_ff[i] <= mopa_in[i];
            mopb_ff[i] <= mopb_in[i];
         end
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_pmul
      rci_wmul u_mul (
         .clock (clock),
         .en    (en),
         .op_a  (mopa_ff[i]),
         .op_b  (mopb_ff[i]),
         .prod  (mprod[i])
      );
   end

   // rounded numerator 2*N*d + a, then its magnitude
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         top77_in[i] = sb_ff[MUL_LAT-1].neg[i]
            ? {{(TW-AW){1'b0}}, sb_ff[MUL_LAT-1].a} - {1'b0, mprod[i][TW-3:0], 1'b0}
            : {{(TW-AW){1'b0}}, sb_ff[MUL_LAT-1].a} + {1'b0, mprod[i][TW-3:0], 1'b0};
      end
      s78_in = s77_ff;
      for (int i = 0; i < 4; i++) begin
         s78_in.neg[i] = top77_ff[i][TW-1];
         tabs78_in[i]  = top77_ff[i][TW-1] ? TMW'(-top77_ff[i]) : TMW'(top77_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= s73_ff;
         for (int i = 1; i < MUL_LAT; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
         s77_ff <= sb_ff[MUL_LAT-1];
         s78_ff <= s78_in;
         for (int i = 0; i < 4; i++) begin
            top77_ff[i]  <= top77_in[i];
            tabs78_ff[i] <= tabs78_in[i];
         end
         sc_ff[0] <= s78_ff;
         for (int i = 1; i < QW; i++) begin
            sc_ff[i] <= sc_ff[i-1];
         end
         res_ff <= res_in;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_div
      rci_div u_div (
         .clock  (clock),
         .en     (en),
         .num    (tabs78_ff[i]),
         .den    ({s78_ff.a, 1'b0}),
         .quo    (dquo[i]),
         .rem_nz (drnz[i])
      );
   end

   // floor, offset by origin, saturate, blank unused slots
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pt[i] = {{(FW-QW){1'b0}}, dquo[i]};
         if (sc_ff[QW-1].neg[i]) begin
            pt[i] = -(pt[i] + {{(FW-1){1'b0}}, drnz[i]});
         end
         pt[i] = pt[i] + ((i % 2 == 0) ? FW'(sc_ff[QW-1].ox) : FW'(sc_ff[QW-1].oy));
         if (pt[i] > PMAX) begin
            pt[i] = PMAX;
         end else if (pt[i] < PMIN) begin
            pt[i] = PMIN;
         end
      end
      res_in.cnt = sc_ff[QW-1].cnt;
      res_in.fx  = (res_in.cnt != 2'd0) ? pt[0][CW-1:0] : '0;
      res_in.fy  = (res_in.cnt != 2'd0) ? pt[1][CW-1:0] : '0;
      res_in.sx  = (res_in.cnt == 2'd2) ? pt[2][CW-1:0] : '0;
      res_in.sy  = (res_in.cnt == 2'd2) ? pt[3][CW-1:0] : '0;
   end

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= pv;
            if (pv) begin
               out_ff <= res_ff;
            end
         end
      end else if (pv) begin
         skid_ff       <= res_ff;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_hit_count = out_ff.cnt;
   assign rsp_first_x   = out_ff.fx;
   assign rsp_first_y   = out_ff.fy;
   assign rsp_second_x  = out_ff.sx;
   assign rsp_second_y  = out_ff.sy;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_count != 2'd3)
      else $error("hit count out of range");

   a_second_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit_count != 2'd2) |-> (rsp_second_x == '0 && rsp_second_y == '0))
      else $error("unused second slot not zero");

   a_first_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit_count == 2'd0) |-> (rsp_first_x == '0 && rsp_first_y == '0))
      else $error("unused first slot not zero");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

endmodule
